@@ hdl/dpf_pkg.sv @@
package dpf_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;

    localparam int LIMIT_W     = 7;
    localparam int APB_AW      = 2;
    localparam int APB_DW      = 32;
    localparam int MATCH_W     = 7;
    localparam int MATCH_MAX   = 127;

    localparam logic [APB_AW-1:0]  REG_MEMORY_LIMIT   = 2'd0;
    localparam logic [LIMIT_W-1:0] MEMORY_LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FWD   = 2'd1,
        OP_COUNT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
        logic [31:0] ts;
    } pkt_t;

    typedef struct packed {
        pkt_t        pkt;
        logic [31:0] win_lo;
        logic [31:0] win_hi;
    } key_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

@@ hdl/dpf_cell.sv @@
module dpf_cell import dpf_pkg::*; (
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  pkt_t      new_pkt,
    input  pkt_t      right_pkt,
    input  key_t      key,
    output pkt_t      pkt,
    output logic      dup_hit,
    output logic      cnt_hit
);

    pkt_t pkt_reg;
    logic dup_reg;
    logic cnt_reg;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            pkt_reg <= new_pkt;
        end else if (ctl.shift) begin
            pkt_reg <= right_pkt;
        end
        dup_reg <= occupied && (pkt_reg == key.pkt);
        cnt_reg <= occupied && (pkt_reg.dst == key.pkt.dst)
                   && (pkt_reg.ts >= key.win_lo) && (pkt_reg.ts <= key.win_hi);
    end

    assign pkt     = pkt_reg;
    assign dup_hit = dup_reg;
    assign cnt_hit = cnt_reg;

endmodule

@@ hdl/dpf_tree.sv @@
module dpf_tree import dpf_pkg::*; #(
    parameter int N = DEF_QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic [N-1:0]           leaves,
    output logic [$clog2(N+1)-1:0] sum
);

    localparam int L  = $clog2(N);
    localparam int P  = 1 << L;
    localparam int CW = $clog2(N + 1);

    logic [P-1:0]  leaf_pad;
    logic [CW-1:0] node_reg [1:P-1];

    assign leaf_pad = P'(leaves);

    // heap layout: node k sums nodes 2k and 2k+1, leaves sit at P..2P-1
    always_ff @(posedge aclk) begin
        for (int k = 1; k < P; k++) begin
            if (2 * k >= P) begin
                node_reg[k] <= CW'(leaf_pad[2 * k - P]) + CW'(leaf_pad[2 * k + 1 - P]);
            end else begin
                node_reg[k] <= CW'(node_reg[2 * k] + node_reg[2 * k + 1]);
            end
        end
    end

    assign sum = node_reg[1];

endmodule

@@ hdl/dedup_packet_fifo_with_range_count.sv @@
// Channel  | Ports                                          | Beat
// ---------+------------------------------------------------+--------------------------
// input    | s_valid s_ready s_operation .. s_window_end    | one operation
// result   | m_valid m_ready m_added .. m_match_count       | one result per operation
// config   | psel penable pwrite paddr pwdata prdata pready | memory_limit at 0x0
//
// Add, forward: accept, compare in all cells, apply.
// Count: accept, compare in all cells, sum in the registered adder tree over the cells, apply.
// One operation in flight; the next beat is taken once the result sits in the output register.
// A stalled m_ready holds the apply step until the output register frees.
// Reset empties the queue and sets memory_limit to 64; no clearing pass.
module dedup_packet_fifo_with_range_count import dpf_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [15:0]       s_source,
    input  logic [15:0]       s_destination,
    input  logic [31:0]       s_timestamp,
    input  logic [31:0]       s_window_start,
    input  logic [31:0]       s_window_end,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_added,
    output logic              m_found,
    output logic [15:0]       m_out_source,
    output logic [15:0]       m_out_destination,
    output logic [31:0]       m_out_timestamp,
    output logic [MATCH_W-1:0] m_match_count,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IW   = $clog2(QUEUE_DEPTH);
    localparam int OW   = $clog2(QUEUE_DEPTH + 1);
    localparam int L    = $clog2(QUEUE_DEPTH);
    localparam int TW   = $clog2(L + 1);
    localparam int CMPW = (OW > LIMIT_W) ? OW : LIMIT_W;
    localparam int SW   = (OW > MATCH_W) ? OW : MATCH_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MATCH = 4'b0010,
        ST_SUM   = 4'b0100,
        ST_APPLY = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [TW-1:0]       timer_reg, timer_next;
    logic [OW-1:0]       occ_reg, occ_next;
    logic [LIMIT_W-1:0]  limit_reg;
    op_t                 op_reg;
    key_t                key_reg;

    logic                m_valid_reg;
    logic                added_reg;
    logic                found_reg;
    pkt_t                out_pkt_reg;
    logic [MATCH_W-1:0]  count_reg;

    pkt_t                cell_pkt [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] dup_vec;
    logic [QUEUE_DEPTH-1:0] cnt_vec;
    logic [OW-1:0]       tree_sum;

    logic                do_apply, dup, add_ok, drop, fwd_ok, shift;
    logic [IW-1:0]       target;
    logic [CMPW-1:0]     occ_x, lim_x;
    logic [SW-1:0]       sum_x;
    logic [MATCH_W-1:0]  count_sat;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= MEMORY_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_MEMORY_LIMIT) begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_MEMORY_LIMIT) ? APB_DW'(limit_reg) : '0;

    // control
    assign do_apply = (state_reg == ST_APPLY) && (!m_valid_reg || m_ready);
    assign dup      = |dup_vec;
    assign add_ok   = (op_reg == OP_ADD) && !dup;
    assign occ_x    = CMPW'(occ_reg);
    assign lim_x    = CMPW'(limit_reg);
    assign drop     = add_ok && (occ_reg != '0)
                      && ((occ_x >= lim_x) || (occ_reg == OW'(QUEUE_DEPTH)));
    assign fwd_ok   = (op_reg == OP_FWD) && (occ_reg != '0);
    assign shift    = do_apply && (drop || fwd_ok);
    assign target   = drop ? IW'(occ_reg - OW'(1)) : IW'(occ_reg);

    always_comb begin
        state_next = state_reg;
        timer_next = timer_reg;
        occ_next   = occ_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MATCH;
            end
            ST_MATCH: begin
                timer_next = '0;
                state_next = (op_reg == OP_COUNT) ? ST_SUM : ST_APPLY;
            end
            ST_SUM: begin
                timer_next = timer_reg + TW'(1);
                if (timer_reg == TW'(L - 1)) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (do_apply) begin
                    state_next = ST_IDLE;
                    if (add_ok && !drop) begin
                        occ_next = occ_reg + OW'(1);
                    end else if (fwd_ok) begin
                        occ_next = occ_reg - OW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            timer_reg <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            timer_reg <= timer_next;
            occ_reg   <= occ_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg         <= op_t'(s_operation);
            key_reg.pkt    <= '{src: s_source, dst: s_destination, ts: s_timestamp};
            key_reg.win_lo <= s_window_start;
            key_reg.win_hi <= s_window_end;
        end
    end

    // cell row, cell 0 holds the oldest packet
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        cell_ctl_t ctl;
        pkt_t      right_pkt;

        assign ctl = '{shift: shift, load: do_apply && add_ok && (target == IW'(i))};
        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_pkt = '0;
        end else begin : g_mid
            assign right_pkt = cell_pkt[i + 1];
        end

        dpf_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .occupied  (OW'(i) < occ_reg),
            .new_pkt   (key_reg.pkt),
            .right_pkt (right_pkt),
            .key       (key_reg),
            .pkt       (cell_pkt[i]),
            .dup_hit   (dup_vec[i]),
            .cnt_hit   (cnt_vec[i])
        );
    end

    dpf_tree #(
        .N (QUEUE_DEPTH)
    ) u_tree (
        .aclk   (aclk),
        .leaves (cnt_vec),
        .sum    (tree_sum)
    );

    assign sum_x     = SW'(tree_sum);
    assign count_sat = (sum_x > SW'(MATCH_MAX)) ? MATCH_W'(MATCH_MAX) : sum_x[MATCH_W-1:0];

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_apply) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_apply) begin
            added_reg   <= add_ok;
            found_reg   <= fwd_ok;
            out_pkt_reg <= fwd_ok ? cell_pkt[0] : '0;
            count_reg   <= (op_reg == OP_COUNT) ? count_sat : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_added           = added_reg;
    assign m_found           = found_reg;
    assign m_out_source      = out_pkt_reg.src;
    assign m_out_destination = out_pkt_reg.dst;
    assign m_out_timestamp   = out_pkt_reg.ts;
    assign m_match_count     = count_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_occ_only_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_APPLY |=> $stable(occ_reg))
        else $error("occupancy moved outside apply");

    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_added, m_found, m_match_count != '0}))
        else $error("result mixes operations");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("pending result lost");

endmodule
